>>> rtl/core/lcs_pkg.sv
// lcs_pkg: shared types and constants for the led cube scan driver
// command codes, control state, store and serializer request structs
// no dependencies
`default_nettype none

package lcs_pkg;

    localparam int unsigned LAYERS     = 4;
    localparam int unsigned ROWS       = 4;
    localparam int unsigned COLS       = 4;
    localparam int unsigned PAT_W      = ROWS * COLS;
    localparam int unsigned HALF_W     = PAT_W / 2;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned ADDR_W     = $clog2(LAYERS);
    localparam int unsigned CNT_W      = $clog2(WORD_W);
    localparam int unsigned SEL_W      = $clog2(WORD_W - HALF_W);
    localparam int unsigned LAYER_NUM_W = 3;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_WRITE_ALL = 2'd2,
        CMD_COPY      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_COPY_RD,
        S_TICK_RD,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [PAT_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_store_req;

    typedef struct packed {
        logic              load;
        logic [HALF_W-1:0] half;
        logic [SEL_W-1:0]  sel;
    } t_ser_load;

endpackage

`default_nettype wire

>>> rtl/core/led_cube_scan_driver.sv
// led_cube_scan_driver: top level of the 4x4x4 led cube multiplex scan driver
// control sequencer, scan position and result register
// depends on lcs_pkg, lcs_store, lcs_serial
`default_nettype none

// Usage
//   input channel: i_in_valid / o_in_stall with i_cmd, i_target_layer,
//   i_source_layer, i_pattern_bits; an item is taken when valid is high
//   and stall is low. output channel: o_out_valid / i_out_stall with
//   o_drive_word, o_shown_layer, o_shown_group.
//   write and bad-layer commands finish in S_IDLE; copy reads the source and
//   writes it in S_COPY_RD; write-all fills all four entries in S_FILL (one
//   store entry per cycle through the single write port). a refresh tick
//   reads the store (registered read), shifts the 16-bit drive word together
//   one bit per cycle in the serializer and lands it in the output register
//   from S_SHIFT; the next item is taken after the return to S_IDLE.
//   the block works on one item at a time: o_in_stall is high while a
//   command is in progress.
//   reset clears the scan to layer 1 group 0 and makes all layer patterns
//   read as zero; no clearing pass is needed.
//   if the receiver stalls, the result holds in the output register and a
//   finished tick waits in the serializer until the register frees up.
module led_cube_scan_driver (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_cmd,
    input  wire logic [lcs_pkg::LAYER_NUM_W-1:0]     i_target_layer,
    input  wire logic [lcs_pkg::LAYER_NUM_W-1:0]     i_source_layer,
    input  wire logic [lcs_pkg::PAT_W-1:0]           i_pattern_bits,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [lcs_pkg::WORD_W-1:0]               o_drive_word,
    output logic [lcs_pkg::LAYER_NUM_W-1:0]          o_shown_layer,
    output logic                                     o_shown_group
);

    lcs_pkg::t_state r_state;
    lcs_pkg::t_state n_state;

    logic [lcs_pkg::ADDR_W-1:0]      r_fill;
    logic [lcs_pkg::PAT_W-1:0]       r_pattern;
    logic [lcs_pkg::ADDR_W-1:0]      r_tgt_addr;
    logic [lcs_pkg::LAYER_NUM_W-1:0] r_scan_layer;
    logic                            r_scan_group;

    logic                            r_out_valid;
    logic [lcs_pkg::WORD_W-1:0]      r_drive_word;
    logic [lcs_pkg::LAYER_NUM_W-1:0] r_shown_layer;
    logic                            r_shown_group;

    lcs_pkg::t_cmd       cmd;
    lcs_pkg::t_store_req store_req;
    lcs_pkg::t_ser_load  ser_load;
    logic [lcs_pkg::PAT_W-1:0]  rd_data;
    logic [lcs_pkg::WORD_W-1:0] ser_word;
    logic                       ser_busy;

    logic                       in_accept;
    logic                       tgt_ok;
    logic                       src_ok;
    logic                       out_free;
    logic                       out_load;
    logic [3:0]                 sel_full;

    assign cmd       = lcs_pkg::t_cmd'(i_cmd);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // layer numbers outside 1..4 make a write or copy a no-op
    always_comb begin
        tgt_ok = i_target_layer inside {[3'd1:3'd4]};
        src_ok = i_source_layer inside {[3'd1:3'd4]};
    end

    // select bit position within the high byte: 9 - 2*layer - group
    assign sel_full = 4'd9 - {r_scan_layer, 1'b0} - {3'b000, r_scan_group};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lcs_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (cmd)
                        lcs_pkg::CMD_TICK:      n_state = lcs_pkg::S_TICK_RD;
                        lcs_pkg::CMD_WRITE_ALL: n_state = lcs_pkg::S_FILL;
                        lcs_pkg::CMD_COPY: begin
                            if (tgt_ok && src_ok) begin
                                n_state = lcs_pkg::S_COPY_RD;
                            end
                        end
                        default:                n_state = lcs_pkg::S_IDLE;
                    endcase
                end
            end
            lcs_pkg::S_FILL: begin
                if (r_fill == lcs_pkg::ADDR_W'(lcs_pkg::LAYERS - 1)) begin
                    n_state = lcs_pkg::S_IDLE;
                end
            end
            lcs_pkg::S_COPY_RD: n_state = lcs_pkg::S_IDLE;
            lcs_pkg::S_TICK_RD: n_state = lcs_pkg::S_SHIFT;
            lcs_pkg::S_SHIFT: begin
                if (!ser_busy && out_free) begin
                    n_state = lcs_pkg::S_IDLE;
                end
            end
            default: n_state = lcs_pkg::S_IDLE;
        endcase
    end

    // per-state controls for the store, serializer and result register
    always_comb begin
        store_req = '0;
        ser_load  = '0;
        out_load  = 1'b0;
        case (r_state)
            lcs_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (cmd)
                        lcs_pkg::CMD_TICK: begin
                            store_req.rd_en   = 1'b1;
                            store_req.rd_addr = lcs_pkg::ADDR_W'(r_scan_layer - 1'b1);
                        end
                        lcs_pkg::CMD_WRITE: begin
                            store_req.wr_en   = tgt_ok;
                            store_req.wr_addr = lcs_pkg::ADDR_W'(i_target_layer - 1'b1);
                            store_req.wr_data = i_pattern_bits;
                        end
                        lcs_pkg::CMD_COPY: begin
                            store_req.rd_en   = tgt_ok && src_ok;
                            store_req.rd_addr = lcs_pkg::ADDR_W'(i_source_layer - 1'b1);
                        end
                        default: begin
                            store_req = '0;
                        end
                    endcase
                end
            end
            lcs_pkg::S_FILL: begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = r_fill;
                store_req.wr_data = r_pattern;
            end
            lcs_pkg::S_COPY_RD: begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = r_tgt_addr;
                store_req.wr_data = rd_data;
            end
            lcs_pkg::S_TICK_RD: begin
                ser_load.load = 1'b1;
                ser_load.half = r_scan_group ? rd_data[lcs_pkg::PAT_W-1:lcs_pkg::HALF_W]
                                             : rd_data[lcs_pkg::HALF_W-1:0];
                ser_load.sel  = sel_full[lcs_pkg::SEL_W-1:0];
            end
            lcs_pkg::S_SHIFT: begin
                out_load = !ser_busy && out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lcs_pkg::S_IDLE;
            r_fill       <= '0;
            r_scan_layer <= lcs_pkg::LAYER_NUM_W'(1);
            r_scan_group <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lcs_pkg::S_FILL) begin
                r_fill <= r_fill + 1'b1;
            end else begin
                r_fill <= '0;
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                // group toggles; layer steps after group 1, wrapping 4 to 1
                r_scan_group <= !r_scan_group;
                if (r_scan_group) begin
                    if (r_scan_layer >= lcs_pkg::LAYER_NUM_W'(lcs_pkg::LAYERS)) begin
                        r_scan_layer <= lcs_pkg::LAYER_NUM_W'(1);
                    end else begin
                        r_scan_layer <= r_scan_layer + 1'b1;
                    end
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload captures, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pattern  <= i_pattern_bits;
            r_tgt_addr <= lcs_pkg::ADDR_W'(i_target_layer - 1'b1);
        end
        if (out_load) begin
            r_drive_word  <= ser_word;
            r_shown_layer <= r_scan_layer;
            r_shown_group <= r_scan_group;
        end
    end

    lcs_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    lcs_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ser_load),
        .o_busy  (ser_busy),
        .o_word  (ser_word)
    );

    assign o_in_stall    = (r_state != lcs_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_drive_word  = r_drive_word;
    assign o_shown_layer = r_shown_layer;
    assign o_shown_group = r_shown_group;

endmodule

`default_nettype wire

>>> rtl/core/lcs_store.sv
// lcs_store: four-entry layer pattern memory, one write and one registered read port
// entries read as zero until first written after reset
// depends on lcs_pkg
`default_nettype none

module lcs_store (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lcs_pkg::t_store_req         i_req,
    output logic [lcs_pkg::PAT_W-1:0]        o_rd_data
);

    logic [lcs_pkg::PAT_W-1:0]  r_mem [lcs_pkg::LAYERS];
    logic [lcs_pkg::LAYERS-1:0] r_written;
    logic [lcs_pkg::PAT_W-1:0]  r_rd_data;
    logic                       r_rd_ok;

    // memory array, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // per-entry written flags stand in for the cleared reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_written[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

`default_nettype wire

>>> rtl/core/lcs_serial.sv
// lcs_serial: builds the drive word one bit per cycle in a shift register
// low byte from the pattern half, high byte ones with one select bit low
// depends on lcs_pkg
`default_nettype none

module lcs_serial (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lcs_pkg::t_ser_load           i_load,
    output logic                              o_busy,
    output logic [lcs_pkg::WORD_W-1:0]        o_word
);

    logic [lcs_pkg::HALF_W-1:0] r_src;
    logic [lcs_pkg::SEL_W-1:0]  r_sel;
    logic [lcs_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_busy;
    logic [lcs_pkg::WORD_W-1:0] r_word;
    logic                       n_bit;

    // bit index below the half width: pattern bit, above: select decode
    always_comb begin
        if (r_cnt < lcs_pkg::CNT_W'(lcs_pkg::HALF_W)) begin
            n_bit = r_src[0];
        end else begin
            n_bit = (r_cnt[lcs_pkg::SEL_W-1:0] != r_sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load.load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == lcs_pkg::CNT_W'(lcs_pkg::WORD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_src <= i_load.half;
            r_sel <= i_load.sel;
        end else if (r_busy) begin
            r_src  <= {1'b0, r_src[lcs_pkg::HALF_W-1:1]};
            r_word <= {n_bit, r_word[lcs_pkg::WORD_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_word = r_word;

endmodule

`default_nettype wire

>>> dv/led_cube_scan_driver_test.sv
// led_cube_scan_driver_test: self-checking bench for the led cube scan driver
// directed table then random commands, drive words checked against a local scan predictor
// depends on lcs_pkg and led_cube_scan_driver
`timescale 1ns / 1ps

module led_cube_scan_driver_test;

    localparam int unsigned DIR_N  = 25;
    localparam int unsigned RAND_N = 1525;
    localparam int unsigned DRAIN_CYCLES = 40;

    // one input item
    typedef struct packed {
        lcs_pkg::t_cmd cmd;
        logic [2:0]    tgt;
        logic [2:0]    src;
        logic [15:0]   pat;
    } t_cube_item;

    // one drive word with its scan position
    typedef struct packed {
        logic [15:0] word;
        logic [2:0]  layer;
        logic        group;
    } t_drive;

    // directed row: item, plus a typed-in drive word where it is obvious
    typedef struct packed {
        t_cube_item item;
        bit         typed;
        t_drive     res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = lcs_pkg::CMD_TICK;
    logic [2:0]  i_target_layer = 3'd0;
    logic [2:0]  i_source_layer = 3'd0;
    logic [15:0] i_pattern_bits = 16'h0000;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_drive_word;
    logic [2:0]  o_shown_layer;
    logic        o_shown_group;

    led_cube_scan_driver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_target_layer (i_target_layer),
        .i_source_layer (i_source_layer),
        .i_pattern_bits (i_pattern_bits),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive_word   (o_drive_word),
        .o_shown_layer  (o_shown_layer),
        .o_shown_group  (o_shown_group)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // predictor state: layer patterns and scan position
    logic [15:0] cube_pat [0:3];
    logic [2:0]  scan_lay;
    logic        scan_grp;

    t_drive      drive_q [$];     // drive words still owed by the block
    int unsigned fail_cnt;
    int unsigned words_seen;

    // directed table: extremes, every command, bad layer numbers, ignored fields
    localparam t_dir_row DIR_ROWS [0:DIR_N-1] = '{
        // first tick after reset: blank layer 1 rows 0-1
        '{'{lcs_pkg::CMD_TICK,      3'd7, 3'd7, 16'hFFFF}, 1'b1, '{16'h7F00, 3'd1, 1'b0}},
        '{'{lcs_pkg::CMD_WRITE,     3'd1, 3'd7, 16'hFFFF}, 1'b0, '0},
        '{'{lcs_pkg::CMD_TICK,      3'd0, 3'd0, 16'h0000}, 1'b1, '{16'hBFFF, 3'd1, 1'b1}},
        '{'{lcs_pkg::CMD_WRITE,     3'd2, 3'd0, 16'hA5C3}, 1'b0, '0},
        // out-of-range targets leave the store alone
        '{'{lcs_pkg::CMD_WRITE,     3'd0, 3'd1, 16'h1234}, 1'b0, '0},
        '{'{lcs_pkg::CMD_WRITE,     3'd5, 3'd2, 16'h1234}, 1'b0, '0},
        '{'{lcs_pkg::CMD_WRITE,     3'd7, 3'd3, 16'hFFFF}, 1'b0, '0},
        '{'{lcs_pkg::CMD_TICK,      3'd2, 3'd5, 16'h5555}, 1'b0, '0},
        '{'{lcs_pkg::CMD_TICK,      3'd4, 3'd6, 16'hAAAA}, 1'b0, '0},
        '{'{lcs_pkg::CMD_COPY,      3'd3, 3'd2, 16'hFFFF}, 1'b0, '0},
        // bad source, bad destination, then a copy onto itself
        '{'{lcs_pkg::CMD_COPY,      3'd3, 3'd0, 16'h0000}, 1'b0, '0},
        '{'{lcs_pkg::CMD_COPY,      3'd6, 3'd1, 16'h0F0F}, 1'b0, '0},
        '{'{lcs_pkg::CMD_COPY,      3'd4, 3'd4, 16'hF0F0}, 1'b0, '0},
        '{'{lcs_pkg::CMD_TICK,      3'd1, 3'd1, 16'h0000}, 1'b0, '0},
        '{'{lcs_pkg::CMD_TICK,      3'd1, 3'd1, 16'h0000}, 1'b0, '0},
        // layer 4 still blank (only copied onto itself): select bits 9 and 8
        '{'{lcs_pkg::CMD_TICK,      3'd1, 3'd1, 16'hFFFF}, 1'b1, '{16'hFD00, 3'd4, 1'b0}},
        '{'{lcs_pkg::CMD_TICK,      3'd1, 3'd1, 16'hFFFF}, 1'b1, '{16'hFE00, 3'd4, 1'b1}},
        // scan wraps back to layer 1
        '{'{lcs_pkg::CMD_TICK,      3'd0, 3'd0, 16'h0000}, 1'b1, '{16'h7FFF, 3'd1, 1'b0}},
        '{'{lcs_pkg::CMD_WRITE_ALL, 3'd0, 3'd5, 16'h0000}, 1'b0, '0},
        '{'{lcs_pkg::CMD_TICK,      3'd0, 3'd0, 16'hFFFF}, 1'b1, '{16'hBF00, 3'd1, 1'b1}},
        '{'{lcs_pkg::CMD_WRITE_ALL, 3'd7, 3'd7, 16'hFFFF}, 1'b0, '0},
        '{'{lcs_pkg::CMD_COPY,      3'd1, 3'd4, 16'h0000}, 1'b0, '0},
        '{'{lcs_pkg::CMD_TICK,      3'd3, 3'd6, 16'h0000}, 1'b0, '0},
        '{'{lcs_pkg::CMD_WRITE,     3'd3, 3'd3, 16'h8001}, 1'b0, '0},
        '{'{lcs_pkg::CMD_TICK,      3'd3, 3'd6, 16'h0000}, 1'b0, '0}
    };

    function automatic bit layer_valid(input logic [2:0] n);
        return n inside {[3'd1:3'd4]};
    endfunction

    // apply one item to the scan predictor; returns 1 when a drive word results
    function automatic bit scan_predict(input t_cube_item it, output t_drive res);
        logic [7:0]  half;
        logic [15:0] pat;
        logic [3:0]  sel;
        res = '0;
        case (it.cmd)
            lcs_pkg::CMD_WRITE: begin
                if (layer_valid(it.tgt))
                    cube_pat[it.tgt - 3'd1] = it.pat;
                return 1'b0;
            end
            lcs_pkg::CMD_WRITE_ALL: begin
                for (int i = 0; i < 4; i++)
                    cube_pat[i] = it.pat;
                return 1'b0;
            end
            lcs_pkg::CMD_COPY: begin
                if (layer_valid(it.tgt) && layer_valid(it.src))
                    cube_pat[it.tgt - 3'd1] = cube_pat[it.src - 3'd1];
                return 1'b0;
            end
            default: begin
                pat  = cube_pat[scan_lay - 3'd1];
                half = scan_grp ? pat[15:8] : pat[7:0];
                // active-low layer select: one bit of the upper byte per half-layer
                sel  = 4'(17 - 2 * int'(scan_lay) - int'(scan_grp));
                res.word = {8'hFF, half};
                res.word[sel] = 1'b0;
                res.layer = scan_lay;
                res.group = scan_grp;
                if (scan_grp)
                    scan_lay = (scan_lay == 3'd4) ? 3'd1 : scan_lay + 3'd1;
                scan_grp = ~scan_grp;
                return 1'b1;
            end
        endcase
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // layer numbers mostly in range, sometimes any 3-bit value
    function automatic logic [2:0] pick_layer();
        if ($urandom_range(0, 99) < 85)
            return 3'($urandom_range(1, 4));
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic t_cube_item rand_item();
        t_cube_item  it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            it.cmd = lcs_pkg::CMD_TICK;
        else if (r < 70)
            it.cmd = lcs_pkg::CMD_WRITE;
        else if (r < 78)
            it.cmd = lcs_pkg::CMD_WRITE_ALL;
        else
            it.cmd = lcs_pkg::CMD_COPY;
        it.tgt = pick_layer();
        it.src = pick_layer();
        r = $urandom_range(0, 19);
        if (r == 0)
            it.pat = 16'h0000;
        else if (r == 1)
            it.pat = 16'hFFFF;
        else
            it.pat = 16'($urandom_range(0, 16'hFFFF));
        return it;
    endfunction

    // offer one item and hold it until taken; valid stays high afterwards
    task automatic offer_item(input t_cube_item it, input bit typed, input t_drive typed_res);
        t_drive res;
        i_in_valid     <= 1'b1;
        i_cmd          <= it.cmd;
        i_target_layer <= it.tgt;
        i_source_layer <= it.src;
        i_pattern_bits <= it.pat;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (scan_predict(it, res))
            drive_q.push_back(typed ? typed_res : res);
    endtask

    task automatic sender_gap(input int unsigned n);
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // sender pauses until the block has handed back every drive word
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (drive_q.size() != 0)
            @(posedge i_clk);
    endtask

    // main sequence: reset, directed table, random items, drain
    initial begin : stim_proc
        t_cube_item it;
        bit         tx_calm;
        for (int i = 0; i < 4; i++)
            cube_pat[i] = 16'h0000;
        scan_lay = 3'd1;
        scan_grp = 1'b0;
        tx_calm  = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            offer_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].res);
            sender_gap(pick_gap());
        end
        wait_drained();

        for (int n = 0; n < RAND_N; n++) begin
            // stretches with back-to-back items
            if (n % 120 == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            it = rand_item();
            offer_item(it, 1'b0, '0);
            if (n % 400 == 399)
                wait_drained();
            else if (!tx_calm)
                sender_gap(pick_gap());
        end
        i_in_valid <= 1'b0;

        // wait for the last words, then watch for strays
        while (drive_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // receiver: checks each drive word taken and drives random stall
    initial begin : drive_rx
        int unsigned stall_left;
        int unsigned hold_left;
        bit          rx_calm;
        t_drive      want;
        stall_left = 0;
        hold_left  = 0;
        rx_calm    = 1'b0;
        fail_cnt   = 0;
        words_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                words_seen++;
                if (drive_q.size() == 0) begin
                    $error("drive word %h with nothing outstanding", o_drive_word);
                    fail_cnt++;
                end else begin
                    want = drive_q.pop_front();
                    if (o_drive_word !== want.word) begin
                        $error("drive_word: expected %h, got %h", want.word, o_drive_word);
                        fail_cnt++;
                    end
                    if (o_shown_layer !== want.layer) begin
                        $error("shown_layer: expected %0d, got %0d", want.layer, o_shown_layer);
                        fail_cnt++;
                    end
                    if (o_shown_group !== want.group) begin
                        $error("shown_group: expected %0d, got %0d", want.group, o_shown_group);
                        fail_cnt++;
                    end
                end
                // long hold-off so the block backs up into its input
                if (words_seen == 150 || words_seen == 600)
                    hold_left = $urandom_range(300, 400);
                if (words_seen % 97 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = rx_calm ? 0 : pick_gap();
                i_out_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
